// ----- rtl/core/mbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types and constants for the front parser, message queue and back end.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [3:0] SYS_NIBBLE  = 4'hF;

    // Status high nibble minus eight.
    localparam logic [2:0] MT_NOTE_OFF  = 3'd0;
    localparam logic [2:0] MT_NOTE_ON   = 3'd1;
    localparam logic [2:0] MT_PROG_CHG  = 3'd4;
    localparam logic [2:0] MT_CHAN_PRES = 3'd5;

    localparam int QDepth   = 2;
    localparam int QPtrW    = $clog2(QDepth);
    localparam int QCountW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        EV_NOTE_ON  = 2'd0,
        EV_NOTE_OFF = 2'd1,
        EV_OTHER    = 2'd2
    } t_event_kind;

    // A complete two-data-byte channel message, before note filtering.
    typedef struct packed {
        logic [2:0] msg_type;
        logic [3:0] channel;
        logic [6:0] first;
        logic [6:0] second;
    } t_msg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/core/mbsp_front.sv -----
// ----------------------------------------------------------------------------
// MIDI front parser
// Classifies each byte, tracks sysex and running status, gathers data bytes.
// ----------------------------------------------------------------------------
module mbsp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_midi_byte,
    output logic                o_push,
    output mbsp_pkg::t_msg      o_msg
);
    import mbsp_pkg::*;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DATA1  = 2'd1,
        PH_DATA2  = 2'd2,
        PH_SYSEX  = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_status, n_status;
    logic [3:0] r_channel, n_channel;
    logic [6:0] r_first, n_first;
    logic       push;

    always_comb begin
        n_phase   = r_phase;
        n_status  = r_status;
        n_channel = r_channel;
        n_first   = r_first;
        push      = 1'b0;
        if (i_accept) begin
            if (i_midi_byte == SYSEX_START) begin
                n_phase = PH_SYSEX;
            end else if (i_midi_byte == SYSEX_END) begin
                n_phase = PH_STATUS;
            end else if (i_midi_byte[7:4] == SYS_NIBBLE) begin
                n_phase = r_phase;
            end else if (i_midi_byte[7]) begin
                n_phase   = PH_DATA1;
                n_status  = i_midi_byte[6:4];
                n_channel = i_midi_byte[3:0];
            end else begin
                case (r_phase)
                    PH_DATA1: begin
                        n_first = i_midi_byte[6:0];
                        // One-data-byte messages wait for the next first byte.
                        if (r_status == MT_PROG_CHG || r_status == MT_CHAN_PRES) begin
                            n_phase = PH_DATA1;
                        end else begin
                            n_phase = PH_DATA2;
                        end
                    end
                    PH_DATA2: begin
                        n_phase = PH_DATA1;
                        push    = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STATUS;
            r_status  <= '0;
            r_channel <= '0;
            r_first   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_status  <= n_status;
            r_channel <= n_channel;
            r_first   <= n_first;
        end
    end

    assign o_push         = push;
    assign o_msg.msg_type = r_status;
    assign o_msg.channel  = r_channel;
    assign o_msg.first    = r_first;
    assign o_msg.second   = i_midi_byte[6:0];

endmodule

// ----- rtl/core/mbsp_queue.sv -----
// ----------------------------------------------------------------------------
// MIDI message queue
// Short FIFO that decouples the front parser from the note filter.
// ----------------------------------------------------------------------------
module mbsp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mbsp_pkg::t_msg      i_msg,
    input  logic                i_pop,
    output mbsp_pkg::t_msg      o_msg,
    output mbsp_pkg::t_q_status o_status
);
    import mbsp_pkg::*;

    t_msg               r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCountW-1:0] r_count, n_count;
    logic               do_push, do_pop;

    assign o_status.full  = (r_count == QCountW'(QDepth));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_msg = r_mem[r_rd_ptr];

endmodule

// ----- rtl/core/mbsp_back.sv -----
// ----------------------------------------------------------------------------
// MIDI note filter and output stage
// Applies the held-note table to each message and registers the result.
// ----------------------------------------------------------------------------
module mbsp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbsp_pkg::t_msg      i_msg,
    input  mbsp_pkg::t_q_status i_q_status,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [1:0]          o_event_kind,
    output logic [3:0]          o_channel,
    output logic [2:0]          o_message_type,
    output logic [6:0]          o_first_value,
    output logic [6:0]          o_second_value
);
    import mbsp_pkg::*;

    logic [127:0] r_note_held;
    logic         r_valid;
    t_event_kind  r_kind;
    t_msg         r_msg;

    logic         pop;
    logic         held;
    logic         emit;
    logic         set_held, clr_held;
    t_event_kind  kind;
    logic [6:0]   second;

    assign pop  = !i_q_status.empty && (!r_valid || !i_stall);
    assign held = r_note_held[i_msg.first];

    always_comb begin
        emit     = 1'b1;
        set_held = 1'b0;
        clr_held = 1'b0;
        kind     = EV_OTHER;
        second   = i_msg.second;
        // A note-on with zero velocity is a note-off.
        if (i_msg.msg_type == MT_NOTE_OFF ||
            (i_msg.msg_type == MT_NOTE_ON && i_msg.second == '0)) begin
            kind     = EV_NOTE_OFF;
            second   = '0;
            emit     = held;
            clr_held = held;
        end else if (i_msg.msg_type == MT_NOTE_ON) begin
            kind     = EV_NOTE_ON;
            emit     = !held;
            set_held = !held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_held <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (pop) begin
                r_valid <= emit;
                if (set_held) begin
                    r_note_held[i_msg.first] <= 1'b1;
                end else if (clr_held) begin
                    r_note_held[i_msg.first] <= 1'b0;
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind         <= kind;
            r_msg.msg_type <= i_msg.msg_type;
            r_msg.channel  <= i_msg.channel;
            r_msg.first    <= i_msg.first;
            r_msg.second   <= second;
        end
    end

    assign o_pop          = pop;
    assign o_valid        = r_valid;
    assign o_event_kind   = r_kind;
    assign o_channel      = r_msg.channel;
    assign o_message_type = r_msg.msg_type;
    assign o_first_value  = r_msg.first;
    assign o_second_value = r_msg.second;

endmodule

// ----- rtl/core/midi_byte_stream_parser.sv -----
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Parses raw MIDI bytes with running status and reports channel messages.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   byte in   input      i_valid / o_stall   i_midi_byte
//   event out output     o_valid / i_stall   o_event_kind, o_channel,
//                                            o_message_type, o_first_value,
//                                            o_second_value
//
// One byte is accepted per cycle while the message queue is not full; a
// completed message is written to the queue and then to the output register.
// Reset clears the parse state and the 128-entry held-note table at once.
// o_stall rises only when the two-entry message queue is full.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_midi_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_kind,
    output logic [3:0] o_channel,
    output logic [2:0] o_message_type,
    output logic [6:0] o_first_value,
    output logic [6:0] o_second_value
);
    import mbsp_pkg::*;

    logic      accept;
    logic      push;
    logic      pop;
    t_msg      front_msg;
    t_msg      queue_msg;
    t_q_status q_status;

    assign o_stall = q_status.full;
    assign accept  = i_valid && !q_status.full;

    mbsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_midi_byte (i_midi_byte),
        .o_push      (push),
        .o_msg       (front_msg)
    );

    mbsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_msg    (front_msg),
        .i_pop    (pop),
        .o_msg    (queue_msg),
        .o_status (q_status)
    );

    mbsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_msg          (queue_msg),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_event_kind   (o_event_kind),
        .o_channel      (o_channel),
        .o_message_type (o_message_type),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value)
    );

endmodule

// ----- test/midi_byte_stream_parser_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser checker
// Follows every byte transaction with its own running-status parser and
// held-note table. It queues the events that the parser must report and
// compares each event transaction, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic       i_byte_stall,
    input  logic [7:0] i_midi_byte,
    input  logic       i_event_valid,
    input  logic       i_event_stall,
    input  logic [1:0] i_event_kind,
    input  logic [3:0] i_channel,
    input  logic [2:0] i_message_type,
    input  logic [6:0] i_first_value,
    input  logic [6:0] i_second_value,
    output int         o_pending,
    output int         o_fail_count
);
    import mbsp_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_STATUS = 2'd0,
        AWAIT_FIRST  = 2'd1,
        AWAIT_SECOND = 2'd2,
        IN_SYSEX     = 2'd3
    } t_parse_phase;

    typedef struct packed {
        t_event_kind kind;
        logic [3:0]  channel;
        logic [2:0]  msg_type;
        logic [6:0]  first;
        logic [6:0]  second;
    } t_midi_event;

    t_parse_phase phase;
    logic [2:0]   latched_type;
    logic [3:0]   latched_channel;
    logic [6:0]   held_first;
    logic [127:0] key_down;
    t_midi_event  expected_events[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic check_event();
        t_midi_event want;
        if (expected_events.size() == 0) begin
            report_mismatch($sformatf("event kind %0d ch %0d key %0d with none expected",
                                      i_event_kind, i_channel, i_first_value));
        end else begin
            want = expected_events.pop_front();
            if (i_event_kind != want.kind)
                report_mismatch($sformatf("event_kind %0d, expected %0d",
                                          i_event_kind, want.kind));
            if (i_channel != want.channel)
                report_mismatch($sformatf("channel %0d, expected %0d",
                                          i_channel, want.channel));
            if (i_message_type != want.msg_type)
                report_mismatch($sformatf("message_type %0d, expected %0d",
                                          i_message_type, want.msg_type));
            if (i_first_value != want.first)
                report_mismatch($sformatf("first_value %0d, expected %0d",
                                          i_first_value, want.first));
            if (i_second_value != want.second)
                report_mismatch($sformatf("second_value %0d, expected %0d",
                                          i_second_value, want.second));
        end
    endtask

    task automatic track_byte(input logic [7:0] b);
        t_midi_event ev;
        logic [6:0]  second;
        if (b == SYSEX_START) begin
            phase = IN_SYSEX;
        end else if (b == SYSEX_END) begin
            phase = AWAIT_STATUS;
        end else if (b[7:4] == SYS_NIBBLE) begin
            // Real-time and common system bytes leave the parse state alone.
        end else if (b[7]) begin
            phase           = AWAIT_FIRST;
            latched_type    = b[6:4];
            latched_channel = b[3:0];
        end else if (phase == AWAIT_FIRST) begin
            held_first = b[6:0];
            if (latched_type == MT_PROG_CHG || latched_type == MT_CHAN_PRES)
                phase = AWAIT_FIRST;
            else
                phase = AWAIT_SECOND;
        end else if (phase == AWAIT_SECOND) begin
            phase       = AWAIT_FIRST;
            second      = b[6:0];
            ev.channel  = latched_channel;
            ev.msg_type = latched_type;
            ev.first    = held_first;
            ev.second   = second;
            // The held-note table is shared by all channels.
            if (latched_type == MT_NOTE_OFF || (latched_type == MT_NOTE_ON && second == 7'd0)) begin
                if (key_down[held_first]) begin
                    key_down[held_first] = 1'b0;
                    ev.kind   = EV_NOTE_OFF;
                    ev.second = 7'd0;
                    expected_events.push_back(ev);
                end
            end else if (latched_type == MT_NOTE_ON) begin
                if (!key_down[held_first]) begin
                    key_down[held_first] = 1'b1;
                    ev.kind = EV_NOTE_ON;
                    expected_events.push_back(ev);
                end
            end else begin
                ev.kind = EV_OTHER;
                expected_events.push_back(ev);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase           = AWAIT_STATUS;
            latched_type    = 3'd0;
            latched_channel = 4'd0;
            held_first      = 7'd0;
            key_down        = '0;
            expected_events.delete();
        end else begin
            // An event can never come from a byte taken on the same edge.
            if (i_event_valid && !i_event_stall)
                check_event();
            if (i_byte_valid && !i_byte_stall)
                track_byte(i_midi_byte);
        end
        o_pending = expected_events.size();
    end

endmodule

// ----- test/midi_byte_stream_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Feeds directed byte sequences and then random running-status messages,
// system exclusive blocks, system bytes and noise, with random gaps on the
// byte side and random stalls on the event side. The checker beside the
// parser predicts and compares every event.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_tb;
    import mbsp_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BYTES   = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] midi_byte = 8'd0;
    logic       event_valid;
    logic       event_stall = 1'b0;
    logic [1:0] event_kind;
    logic [3:0] channel;
    logic [2:0] message_type;
    logic [6:0] first_value;
    logic [6:0] second_value;

    int         pending;
    int         fail_count;
    int         idle_cycles = 0;
    int         stall_hold = 0;
    int         stall_len;
    int         traffic_bytes = 0;
    int         burst_count = 0;
    bit         quiet = 1'b0;
    bit         drained = 1'b0;
    logic [7:0] directed_bytes[$];

    midi_byte_stream_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (byte_valid),
        .o_stall       (byte_stall),
        .i_midi_byte   (midi_byte),
        .o_valid       (event_valid),
        .i_stall       (event_stall),
        .o_event_kind  (event_kind),
        .o_channel     (channel),
        .o_message_type(message_type),
        .o_first_value (first_value),
        .o_second_value(second_value)
    );

    midi_byte_stream_parser_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (byte_valid),
        .i_byte_stall  (byte_stall),
        .i_midi_byte   (midi_byte),
        .i_event_valid (event_valid),
        .i_event_stall (event_stall),
        .i_event_kind  (event_kind),
        .i_channel     (channel),
        .i_message_type(message_type),
        .i_first_value (first_value),
        .i_second_value(second_value),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            event_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (event_stall) begin
            event_stall <= 1'b0;
            stall_hold  <= $urandom_range(0, 15);
        end else begin
            stall_len = pick_gap();
            if (stall_len > 0) begin
                event_stall <= 1'b1;
                stall_hold  <= stall_len - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((byte_valid && !byte_stall) || (event_valid && !event_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_valid <= 1'b1;
        midi_byte  <= b;
        @(posedge i_clk);
        while (byte_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_events_drained();
        byte_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Any system byte other than the sysex start and end markers.
    task automatic send_system_byte();
        logic [7:0] b;
        b = 8'hF1 + 8'($urandom_range(0, 13));
        if (b >= SYSEX_END)
            b = b + 8'd1;
        send_byte(b);
    endtask

    // Half the keys come from a small set so that the held-note table is hit.
    function automatic logic [6:0] pick_key();
        logic [31:0] r;
        r = $urandom;
        if (r[31])
            return {4'd0, r[2:0]};
        return r[6:0];
    endfunction

    task automatic send_channel_burst();
        logic [2:0]  mtype;
        logic [3:0]  chan;
        logic [31:0] r;
        int          roll;
        int          reps;
        roll = $urandom_range(0, 9);
        r    = $urandom;
        if (roll < 3)
            mtype = MT_NOTE_ON;
        else if (roll < 5)
            mtype = MT_NOTE_OFF;
        else
            mtype = r[6:4];
        chan = r[3:0];
        send_byte({1'b1, mtype, chan});
        traffic_bytes++;
        reps = $urandom_range(1, 4);
        repeat (reps) begin
            send_byte({1'b0, pick_key()});
            traffic_bytes++;
            if ($urandom_range(0, 19) == 0)
                send_system_byte();
            if (mtype != MT_PROG_CHG && mtype != MT_CHAN_PRES) begin
                r = $urandom;
                send_byte({1'b0, (r[9:8] == 2'd0) ? 7'd0 : r[6:0]});
                traffic_bytes++;
            end
        end
    endtask

    // Sometimes left open so that a status byte or noise has to end it.
    task automatic send_sysex();
        int len;
        len = $urandom_range(0, 4);
        send_byte(SYSEX_START);
        repeat (len)
            send_byte(8'($urandom_range(0, 127)));
        if ($urandom_range(0, 9) < 7)
            send_byte(SYSEX_END);
    endtask

    initial begin
        directed_bytes = '{
            8'h45,                      // data with no status yet
            8'h90, 8'h00, 8'h7F,        // note on, key 0
            8'h9F, 8'h00, 8'h01,        // repeated note on, other channel
            8'h00, 8'h00,               // velocity zero under running status
            8'h80, 8'h7F, 8'h7F,        // note off for a key not held
            8'h90, 8'h7F, 8'h01,
            8'h8F, 8'h7F, 8'h55,
            8'hB3, 8'h07, 8'h64,
            8'hF0, 8'h12, 8'hF7, 8'h11, // data after sysex end is ignored
            8'hF0, 8'h01, 8'hE5, 8'h7F, 8'h7F,
            8'hA2, 8'h10, 8'hFF, 8'h20,
            8'hC1, 8'h05, 8'h06,
            8'hD2, 8'h33
        };
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        wait_events_drained();

        while (traffic_bytes < RANDOM_BYTES) begin
            if (burst_count % 20 == 0)
                quiet = ($urandom_range(0, 5) == 0);
            burst_count++;
            case ($urandom_range(0, 19)) inside
                [0:14]:  send_channel_burst();
                [15:16]: send_sysex();
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
            if (!drained && traffic_bytes >= RANDOM_BYTES / 2) begin
                wait_events_drained();
                drained = 1'b1;
            end
        end

        wait_events_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mbsp_pkg.sv
rtl/core/mbsp_front.sv
rtl/core/mbsp_queue.sv
rtl/core/mbsp_back.sv
rtl/core/midi_byte_stream_parser.sv
test/midi_byte_stream_parser_checker.sv
test/midi_byte_stream_parser_tb.sv
